FILE: design/multi_pattern_first_match_macros.svh
// assertion helpers for the multi-pattern first match block
`ifndef MULTI_PATTERN_FIRST_MATCH_MACROS_SVH
`define MULTI_PATTERN_FIRST_MATCH_MACROS_SVH

// same-cycle implication, checked outside reset
`define MPFM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MPFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mpfm_pkg.sv
package mpfm_pkg;

    // default sizing
    localparam int NUM_PATTERNS_DFLT = 8;
    localparam int PAT_MAX_LEN_DFLT  = 16;
    localparam int HAY_MAX_LEN_DFLT  = 65535;

    // fixed field widths
    localparam int OP_W    = 2;
    localparam int SLOT_W  = 3;
    localparam int OFFS_W  = 4;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 5;
    localparam int COUNT_W = 4;
    localparam int POS_W   = 16;
    localparam int IDX_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_BYTE = 2'd0,
        OP_SET_LEN   = 2'd1,
        OP_HAY_BYTE  = 2'd2,
        OP_END       = 2'd3
    } t_op;

endpackage

FILE: design/multi_pattern_first_match.sv
// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_ready   operation, slot, offset, byte, length, present
// out      output     o_out_valid / i_out_ready found, match_position, pattern_index, overflow
// cfg      input      i_cfg_valid / o_cfg_ready pattern_count (4 bits)
//
// one transaction per cycle on the input unless it stalls; it is held in the input register
// and applied from there, and an end transaction loads the result register, from which its
// result is handed out
// every slot is compared against the byte window combinationally for each haystack byte
// only an end transaction meeting a full, untaken output register stalls, and every
// transaction behind it waits with it; no other operation ever stalls the input
// reset is synchronous: lengths, flags, window, counters and pattern_count clear,
// the pattern byte store is left as it is and must be loaded before use
module multi_pattern_first_match #(
    parameter int NUM_PATTERNS = mpfm_pkg::NUM_PATTERNS_DFLT,
    parameter int PAT_MAX_LEN  = mpfm_pkg::PAT_MAX_LEN_DFLT,
    parameter int HAY_MAX_LEN  = mpfm_pkg::HAY_MAX_LEN_DFLT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [mpfm_pkg::OP_W-1:0]     i_operation,
    input  logic [mpfm_pkg::SLOT_W-1:0]   i_pattern_slot,
    input  logic [mpfm_pkg::OFFS_W-1:0]   i_byte_offset,
    input  logic [mpfm_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic [mpfm_pkg::LEN_W-1:0]    i_pattern_length,
    input  logic                          i_pattern_present,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [mpfm_pkg::POS_W-1:0]    o_match_position,
    output logic [mpfm_pkg::IDX_W-1:0]    o_pattern_index,
    output logic                          o_overflow,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mpfm_pkg::COUNT_W-1:0]  i_cfg_data
);

`include "multi_pattern_first_match_macros.svh"

    localparam int SW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int LW = $clog2(PAT_MAX_LEN + 1);
    localparam int WW = (PAT_MAX_LEN > 1) ? $clog2(PAT_MAX_LEN) : 1;
    localparam int CW = $clog2(HAY_MAX_LEN + 1);
    localparam int BW = mpfm_pkg::BYTE_W;

    // input register
    logic                           r_in_valid;
    mpfm_pkg::t_op                  r_op;
    logic [mpfm_pkg::SLOT_W-1:0]    r_slot;
    logic [mpfm_pkg::OFFS_W-1:0]    r_offset;
    logic [BW-1:0]                  r_byte;
    logic [mpfm_pkg::LEN_W-1:0]     r_plen;
    logic                           r_present;

    // pattern table: byte store has no reset, lengths and flags do
    logic [BW-1:0]                  r_store [NUM_PATTERNS][PAT_MAX_LEN];
    logic [LW-1:0]                  r_len   [NUM_PATTERNS];
    logic [NUM_PATTERNS-1:0]        r_flag;
    logic [mpfm_pkg::COUNT_W-1:0]   r_count;

    // search state, window tap k is the haystack byte taken k bytes before the newest one
    logic [PAT_MAX_LEN-1:0][BW-1:0] r_window;
    logic [CW-1:0]                  r_seen;
    logic                           r_best_found;
    logic [CW-1:0]                  r_best_start;
    logic [SW-1:0]                  r_best_slot;
    logic                           r_overflow;

    // output register
    logic                           r_out_valid;
    logic                           r_out_found;
    logic [mpfm_pkg::POS_W-1:0]     r_out_pos;
    logic [mpfm_pkg::IDX_W-1:0]     r_out_idx;
    logic                           r_out_ovf;

    logic                           proc_go;
    logic                           hay_limit;
    logic [LW-1:0]                  n_len;
    logic [PAT_MAX_LEN-1:0][BW-1:0] n_window;
    logic [CW-1:0]                  n_seen;
    logic [NUM_PATTERNS-1:0]        hit;
    logic                           cand_found;
    logic [LW-1:0]                  cand_len;
    logic [SW-1:0]                  cand_slot;
    logic [CW-1:0]                  cand_start;
    logic                           cand_better;
    logic                           empty_found;
    logic [SW-1:0]                  empty_slot;
    logic                           take_empty;
    logic                           fin_found;
    logic [CW-1:0]                  fin_start;
    logic [SW-1:0]                  fin_slot;
    logic [CW+mpfm_pkg::POS_W-1:0]  fin_pos_ext;
    logic [SW+mpfm_pkg::IDX_W-1:0]  fin_idx_ext;

    // the input register moves on unless an end transaction meets a full output register that is not being taken
    assign proc_go    = r_in_valid && ((r_op != mpfm_pkg::OP_END) || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc_go;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op      <= mpfm_pkg::t_op'(i_operation);
            r_slot    <= i_pattern_slot;
            r_offset  <= i_byte_offset;
            r_byte    <= i_data_byte;
            r_plen    <= i_pattern_length;
            r_present <= i_pattern_present;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    // pattern byte store, out of range slots or offsets are dropped by the decode
    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NUM_PATTERNS; s++) begin
            for (int b = 0; b < PAT_MAX_LEN; b++) begin
                if (proc_go && (r_op == mpfm_pkg::OP_LOAD_BYTE) &&
                    (int'(r_slot) == s) && (int'(r_offset) == b)) begin
                    r_store[s][b] <= r_byte;
                end
            end
        end
    end

    // lengths above the maximum saturate
    always_comb begin
        if (int'(r_plen) > PAT_MAX_LEN) begin
            n_len = LW'(PAT_MAX_LEN);
        end else begin
            n_len = LW'(r_plen);
        end
    end

    assign hay_limit = (int'(r_seen) >= HAY_MAX_LEN);
    assign n_seen    = r_seen + CW'(1);

    // window after taking the current haystack byte
    always_comb begin
        n_window[0] = r_byte;
        for (int k = 1; k < PAT_MAX_LEN; k++) begin
            n_window[k] = r_window[k-1];
        end
    end

    // per slot compare: pattern byte i lines up with window tap len-1-i
    always_comb begin
        for (int s = 0; s < NUM_PATTERNS; s++) begin
            hit[s] = (s < int'(r_count)) && r_flag[s] && (r_len[s] != '0) &&
                     (int'(r_len[s]) <= int'(n_seen));
            for (int i = 0; i < PAT_MAX_LEN; i++) begin
                if (i < int'(r_len[s])) begin
                    if (n_window[WW'(int'(r_len[s]) - 1 - i)] != r_store[s][i]) begin
                        hit[s] = 1'b0;
                    end
                end
            end
        end
    end

    // among this byte's hits the longest pattern starts earliest, lower slot wins a tie
    always_comb begin
        cand_found = 1'b0;
        cand_len   = '0;
        cand_slot  = '0;
        for (int s = 0; s < NUM_PATTERNS; s++) begin
            if (hit[s] && (!cand_found || (r_len[s] > cand_len))) begin
                cand_found = 1'b1;
                cand_len   = r_len[s];
                cand_slot  = SW'(s);
            end
        end
        cand_start  = n_seen - CW'(cand_len);
        cand_better = cand_found && (!r_best_found || (cand_start < r_best_start) ||
                      ((cand_start == r_best_start) && (cand_slot < r_best_slot)));
    end

    // empty present patterns match at position zero, looked at only on the end transaction
    always_comb begin
        empty_found = 1'b0;
        empty_slot  = '0;
        for (int s = NUM_PATTERNS - 1; s >= 0; s--) begin
            if ((s < int'(r_count)) && r_flag[s] && (r_len[s] == '0)) begin
                empty_found = 1'b1;
                empty_slot  = SW'(s);
            end
        end
        take_empty = empty_found && (!r_best_found || (r_best_start != '0) ||
                     (empty_slot < r_best_slot));
        fin_found  = r_best_found || empty_found;
        fin_start  = take_empty ? '0 : r_best_start;
        fin_slot   = take_empty ? empty_slot : r_best_slot;
    end

    // positions and slot keep their low bits on the way out
    assign fin_pos_ext = {{mpfm_pkg::POS_W{1'b0}}, fin_start};
    assign fin_idx_ext = {{mpfm_pkg::IDX_W{1'b0}}, fin_slot};

    // table lengths, flags and search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_PATTERNS; s++) begin
                r_len[s] <= '0;
            end
            r_flag       <= '0;
            r_window     <= '0;
            r_seen       <= '0;
            r_best_found <= 1'b0;
            r_best_start <= '0;
            r_best_slot  <= '0;
            r_overflow   <= 1'b0;
        end else if (proc_go) begin
            case (r_op)
                mpfm_pkg::OP_LOAD_BYTE: begin
                    // store handled on its own
                end
                mpfm_pkg::OP_SET_LEN: begin
                    for (int s = 0; s < NUM_PATTERNS; s++) begin
                        if (int'(r_slot) == s) begin
                            r_len[s]  <= n_len;
                            r_flag[s] <= r_present;
                        end
                    end
                end
                mpfm_pkg::OP_HAY_BYTE: begin
                    if (hay_limit) begin
                        // past the length limit the byte is dropped
                        r_overflow <= 1'b1;
                    end else begin
                        r_window <= n_window;
                        r_seen   <= n_seen;
                        if (cand_better) begin
                            r_best_found <= 1'b1;
                            r_best_start <= cand_start;
                            r_best_slot  <= cand_slot;
                        end
                    end
                end
                mpfm_pkg::OP_END: begin
                    r_window     <= '0;
                    r_seen       <= '0;
                    r_best_found <= 1'b0;
                    r_best_start <= '0;
                    r_best_slot  <= '0;
                    r_overflow   <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // result register, refilled in the cycle it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_go && (r_op == mpfm_pkg::OP_END)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && (r_op == mpfm_pkg::OP_END)) begin
            r_out_found <= fin_found;
            r_out_pos   <= fin_pos_ext[mpfm_pkg::POS_W-1:0];
            r_out_idx   <= fin_idx_ext[mpfm_pkg::IDX_W-1:0];
            r_out_ovf   <= r_overflow;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_out_found;
    assign o_match_position = r_out_pos;
    assign o_pattern_index  = r_out_idx;
    assign o_overflow       = r_out_ovf;

    // a recorded start never lies beyond the bytes taken
    `MPFM_ASSERT_NOW(a_start_in_range, i_clk, i_rst_n, r_best_found, r_best_start <= r_seen, "best start beyond bytes seen")
    // overflow only once the haystack counter has reached the limit
    `MPFM_ASSERT_NOW(a_ovf_at_limit, i_clk, i_rst_n, r_overflow, hay_limit, "overflow below length limit")
    // an empty best record is fully cleared
    `MPFM_ASSERT_NOW(a_idle_best, i_clk, i_rst_n, !r_best_found, (r_best_start == '0) && (r_best_slot == '0), "stale best record")
    // an end transaction gives a result and leaves the search state cleared
    `MPFM_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, proc_go && (r_op == mpfm_pkg::OP_END), r_out_valid && !r_best_found && (r_seen == '0) && !r_overflow, "end transaction did not complete")

endmodule

FILE: tb/sv/first_match_checker.sv
// watches the item, result and register channels of multi_pattern_first_match,
// predicts each end-of-haystack result and compares it with what the block returns
module first_match_checker
    import mpfm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [SLOT_W-1:0]    i_pattern_slot,
    input  logic [OFFS_W-1:0]    i_byte_offset,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic [LEN_W-1:0]     i_pattern_length,
    input  logic                 i_pattern_present,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic                 i_found,
    input  logic [POS_W-1:0]     i_match_position,
    input  logic [IDX_W-1:0]     i_pattern_index,
    input  logic                 i_overflow,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [COUNT_W-1:0]   i_cfg_data,
    output int                   o_mismatch_count,
    output int                   o_results_due
);

    localparam int SLOTS     = NUM_PATTERNS_DFLT;
    localparam int PAT_LEN   = PAT_MAX_LEN_DFLT;
    localparam int HAY_LIMIT = HAY_MAX_LEN_DFLT;

    typedef struct packed {
        logic               found;
        logic [POS_W-1:0]   position;
        logic [IDX_W-1:0]   index;
        logic               overflow;
    } t_match_result;

    // predicted copy of the pattern table and search state
    logic [BYTE_W-1:0]  pat_store [SLOTS][PAT_LEN];
    logic [LEN_W-1:0]   pat_len [SLOTS];
    logic               pat_on [SLOTS];
    logic [BYTE_W-1:0]  window [PAT_LEN];   // [0] is the newest byte
    int                 seen;
    logic               best_hit;
    int                 best_start;
    int                 best_slot;
    logic               hay_overflow;
    logic [COUNT_W-1:0] slots_in_use;

    t_match_result      expected_results [$];
    int                 mismatch_count = 0;
    int                 due_count = 0;

    assign o_mismatch_count = mismatch_count;
    assign o_results_due    = due_count;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void clear_search();
        foreach (window[k])
            window[k] = '0;
        seen         = 0;
        best_hit     = 1'b0;
        best_start   = 0;
        best_slot    = 0;
        hay_overflow = 1'b0;
    endfunction

    function automatic void reset_model();
        foreach (pat_store[s, i])
            pat_store[s][i] = '0;
        foreach (pat_len[s]) begin
            pat_len[s] = '0;
            pat_on[s]  = 1'b0;
        end
        slots_in_use = '0;
        clear_search();
    endfunction

    function automatic int active_slot_count();
        return (int'(slots_in_use) > SLOTS) ? SLOTS : int'(slots_in_use);
    endfunction

    function automatic void offer_candidate(input int start, input int slot);
        if (!best_hit || start < best_start || (start == best_start && slot < best_slot)) begin
            best_hit   = 1'b1;
            best_start = start;
            best_slot  = slot;
        end
    endfunction

    function automatic void take_hay_byte(input logic [BYTE_W-1:0] data);
        int  slot_limit;
        int  l;
        bit  hit;
        if (seen >= HAY_LIMIT) begin
            hay_overflow = 1'b1;
            return;
        end
        for (int k = PAT_LEN - 1; k > 0; k--)
            window[k] = window[k-1];
        window[0] = data;
        seen++;
        slot_limit = active_slot_count();
        for (int s = 0; s < slot_limit; s++) begin
            l = int'(pat_len[s]);
            if (pat_on[s] && l > 0 && l <= seen) begin
                hit = 1'b1;
                for (int i = 0; i < l; i++)
                    if (window[l-1-i] != pat_store[s][i])
                        hit = 1'b0;
                if (hit)
                    offer_candidate(seen - l, s);
            end
        end
    endfunction

    function automatic t_match_result finish_haystack();
        t_match_result r;
        int            slot_limit;
        slot_limit = active_slot_count();
        // empty patterns only count at the end
        for (int s = 0; s < slot_limit; s++)
            if (pat_on[s] && pat_len[s] == '0)
                offer_candidate(0, s);
        r.found    = best_hit;
        r.position = best_hit ? POS_W'(best_start) : '0;
        r.index    = best_hit ? IDX_W'(best_slot) : '0;
        r.overflow = hay_overflow;
        clear_search();
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_match_result got;
        t_match_result want;
        if (!i_rst_n) begin
            reset_model();
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                slots_in_use = i_cfg_data;

            // results leave before a new end transaction is queued
            if (i_out_valid && i_out_ready) begin
                got = '{i_found, i_match_position, i_pattern_index, i_overflow};
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with none pending (found %0d pos %0d)",
                                              got.found, got.position));
                end else begin
                    want = expected_results.pop_front();
                    if (got.found !== want.found)
                        report_mismatch($sformatf("found: expected %0d got %0d",
                                                  want.found, got.found));
                    if (got.position !== want.position)
                        report_mismatch($sformatf("match_position: expected %0d got %0d",
                                                  want.position, got.position));
                    if (got.index !== want.index)
                        report_mismatch($sformatf("pattern_index: expected %0d got %0d",
                                                  want.index, got.index));
                    if (got.overflow !== want.overflow)
                        report_mismatch($sformatf("overflow: expected %0d got %0d",
                                                  want.overflow, got.overflow));
                end
            end

            if (i_in_valid && i_in_ready) begin
                // slot and offset fields cannot exceed the table at these sizes
                case (t_op'(i_operation))
                    OP_LOAD_BYTE: begin
                        pat_store[i_pattern_slot][i_byte_offset] = i_data_byte;
                    end
                    OP_SET_LEN: begin
                        pat_len[i_pattern_slot] = (i_pattern_length > LEN_W'(PAT_LEN)) ?
                                                  LEN_W'(PAT_LEN) : i_pattern_length;
                        pat_on[i_pattern_slot]  = i_pattern_present;
                    end
                    OP_HAY_BYTE: begin
                        take_hay_byte(i_data_byte);
                    end
                    default: begin
                        expected_results.push_back(finish_haystack());
                    end
                endcase
            end
        end
        due_count = expected_results.size();
    end

endmodule

FILE: tb/sv/tb_multi_pattern_first_match.sv
// top of the multi_pattern_first_match regression: drives the item, result and
// register channels, leaves prediction and comparison to first_match_checker
module tb_multi_pattern_first_match;
    import mpfm_pkg::*;

    localparam int          SLOTS       = NUM_PATTERNS_DFLT;
    localparam int          PAT_LEN     = PAT_MAX_LEN_DFLT;
    localparam int          RANDOM_ITEMS = 1750;
    localparam int          HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;

    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [OP_W-1:0]     in_op = '0;
    logic [SLOT_W-1:0]   in_slot = '0;
    logic [OFFS_W-1:0]   in_offset = '0;
    logic [BYTE_W-1:0]   in_data = '0;
    logic [LEN_W-1:0]    in_len = '0;
    logic                in_present = 1'b0;

    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                out_found;
    logic [POS_W-1:0]    out_position;
    logic [IDX_W-1:0]    out_index;
    logic                out_overflow;

    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [COUNT_W-1:0]  cfg_data = '0;

    int                  mismatch_count;
    int                  results_due;

    // stimulus-side copy of the table, used only to build haystacks that match and to copy pattern heads
    logic [BYTE_W-1:0]   tb_pat [SLOTS][PAT_LEN];
    int                  tb_len [SLOTS];

    int                  items_sent = 0;
    bit                  in_burst = 1'b0;      // no gaps on the item channel when set
    int                  pressure_wanted = 0;  // long receiver hold-offs requested
    int                  pressure_served = 0;  // and carried out
    int unsigned         cycle_count = 0;

    // clock, period 10
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    multi_pattern_first_match uut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_operation       (in_op),
        .i_pattern_slot    (in_slot),
        .i_byte_offset     (in_offset),
        .i_data_byte       (in_data),
        .i_pattern_length  (in_len),
        .i_pattern_present (in_present),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_found           (out_found),
        .o_match_position  (out_position),
        .o_pattern_index   (out_index),
        .o_overflow        (out_overflow),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_data        (cfg_data)
    );

    first_match_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_operation       (in_op),
        .i_pattern_slot    (in_slot),
        .i_byte_offset     (in_offset),
        .i_data_byte       (in_data),
        .i_pattern_length  (in_len),
        .i_pattern_present (in_present),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_found           (out_found),
        .i_match_position  (out_position),
        .i_pattern_index   (out_index),
        .i_overflow        (out_overflow),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_data        (cfg_data),
        .o_mismatch_count  (mismatch_count),
        .o_results_due     (results_due)
    );

    // watchdog: a hang anywhere ends the run as a failure
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("multi_pattern_first_match regression: fail");
            $finish;
        end
    end

    // idle length: mostly none, often short, now and then a long one
    function automatic int pick_gap(input bit no_idle);
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // small alphabet so that random haystacks hit patterns often
    function automatic int alpha_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hff;
            2, 3, 4: return 8'h61;
            5, 6:    return 8'h62;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // register values: the extremes and the over-range codes show up regularly
    function automatic int pick_count();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return SLOTS;
            2:       return $urandom_range(SLOTS + 1, 15);
            default: return $urandom_range(1, SLOTS);
        endcase
    endfunction

    // one transaction on the item channel; valid stays high across back-to-back items
    task automatic send_item(input t_op op, input logic [SLOT_W-1:0] slot,
                             input logic [OFFS_W-1:0] offset, input logic [BYTE_W-1:0] data,
                             input logic [LEN_W-1:0] len, input logic present);
        int gap;
        gap = pick_gap(in_burst);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_op      <= op;
        in_slot    <= slot;
        in_offset  <= offset;
        in_data    <= data;
        in_len     <= len;
        in_present <= present;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // fields an operation does not use are filled with random values
    task automatic load_byte(input int slot, input int offset, input int data);
        tb_pat[slot][offset] = BYTE_W'(data);
        send_item(OP_LOAD_BYTE, SLOT_W'(slot), OFFS_W'(offset), BYTE_W'(data),
                  LEN_W'($urandom), 1'($urandom));
    endtask

    task automatic set_length(input int slot, input int len, input bit present);
        tb_len[slot] = (len > PAT_LEN) ? PAT_LEN : len;
        send_item(OP_SET_LEN, SLOT_W'(slot), OFFS_W'($urandom), BYTE_W'($urandom),
                  LEN_W'(len), present);
    endtask

    task automatic hay_byte(input int data);
        send_item(OP_HAY_BYTE, SLOT_W'($urandom), OFFS_W'($urandom), BYTE_W'(data),
                  LEN_W'($urandom), 1'($urandom));
    endtask

    task automatic end_haystack();
        send_item(OP_END, SLOT_W'($urandom), OFFS_W'($urandom), BYTE_W'($urandom),
                  LEN_W'($urandom), 1'($urandom));
    endtask

    // block is idle once every result is back and the last transaction has drained
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (results_due != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_count(input int value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= COUNT_W'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // any operation with random fields, end transactions included
    task automatic noise_item();
        case ($urandom_range(0, 3))
            0:       load_byte($urandom_range(0, SLOTS - 1), $urandom_range(0, PAT_LEN - 1),
                               $urandom_range(0, 255));
            1:       set_length($urandom_range(0, SLOTS - 1), $urandom_range(0, 31),
                                1'($urandom));
            2:       hay_byte($urandom_range(0, 255));
            default: end_haystack();
        endcase
    endtask

    // redefine a few slots; some patterns copy the head of another slot to force ties
    task automatic define_table();
        int s;
        int src;
        int l;
        int eff;
        int r;
        bit copy_head;
        repeat ($urandom_range(1, 4)) begin
            s = $urandom_range(0, SLOTS - 1);
            r = $urandom_range(0, 99);
            if (r < 8)
                l = 0;
            else if (r < 80)
                l = $urandom_range(1, 5);
            else if (r < 95)
                l = $urandom_range(6, PAT_LEN);
            else
                l = $urandom_range(PAT_LEN + 1, 31);
            eff       = (l > PAT_LEN) ? PAT_LEN : l;
            src       = $urandom_range(0, SLOTS - 1);
            copy_head = (src != s) && ($urandom_range(0, 9) < 3);
            for (int i = 0; i < eff; i++) begin
                if (copy_head && i < tb_len[src])
                    load_byte(s, i, tb_pat[src][i]);
                else
                    load_byte(s, i, alpha_byte());
            end
            set_length(s, l, $urandom_range(0, 9) != 0);
        end
    endtask

    // haystack bytes with whole patterns dropped in and the odd stray transaction
    task automatic stream_haystack(input int n);
        int k;
        int s;
        int r;
        k = 0;
        while (k < n) begin
            r = $urandom_range(0, 99);
            s = $urandom_range(0, SLOTS - 1);
            if (r < 15 && tb_len[s] > 0) begin
                for (int i = 0; i < tb_len[s]; i++)
                    hay_byte(tb_pat[s][i]);
                k += tb_len[s];
            end else if (r >= 97) begin
                noise_item();
                k++;
            end else begin
                hay_byte(alpha_byte());
                k++;
            end
        end
    endtask

    // receiver: random ready with stalls of varied length, long stretches of ready,
    // and on request a long hold-off counted here while the sender keeps going
    initial begin : receiver
        int span;
        int k;
        int hold;
        bit go;
        forever begin
            if (pressure_served < pressure_wanted) begin
                out_ready <= 1'b0;
                hold = 0;
                while (hold < HOLD_CYCLES) begin
                    @(posedge clk);
                    hold++;
                end
                pressure_served++;
            end else begin
                go = ($urandom_range(0, 2) != 0);
                out_ready <= go;
                if (go)
                    span = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                       : $urandom_range(1, 20);
                else
                    span = 1 + pick_gap(1'b0);
                k = 0;
                // the loop body always runs, so no two assignments share a time step
                do begin
                    @(posedge clk);
                    k++;
                end while (k < span && pressure_served >= pressure_wanted);
            end
        end
    end

    initial begin : stimulus
        int phase_start;
        int round;
        int n;

        // synchronous reset
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // straight out of reset: no slots in use, nothing can be found
        end_haystack();

        // fill the whole pattern store so that no compare ever reads an unset byte
        in_burst = 1'b1;
        for (int s = 0; s < SLOTS; s++)
            for (int i = 0; i < PAT_LEN; i++)
                load_byte(s, i, $urandom_range(0, 255));
        for (int s = 0; s < SLOTS; s++)
            tb_len[s] = 0;
        in_burst = 1'b0;

        // directed: count above the slot total, longest pattern in the top slot,
        // over-long length that saturates, zero and all-ones bytes, an empty pattern
        set_count(15);
        set_length(SLOTS - 1, PAT_LEN, 1'b1);
        set_length(0, 31, 1'b1);
        load_byte(SLOTS - 1, PAT_LEN - 1, 8'hff);
        load_byte(SLOTS - 1, 0, 8'h00);
        for (int i = 0; i < PAT_LEN; i++)
            hay_byte(tb_pat[SLOTS - 1][i]);
        end_haystack();
        set_length(3, 0, 1'b1);
        end_haystack();

        // random part: mostly well-formed table/haystack/end rounds
        phase_start = items_sent;
        round = 0;
        while (items_sent - phase_start < RANDOM_ITEMS) begin
            round++;
            in_burst = ($urandom_range(0, 4) == 0);
            if (round == 15 || round == 60) begin
                // receiver stops for a long stretch; end transactions pile up
                // behind the output register until the item channel stalls
                pressure_wanted++;
                wait (pressure_served < pressure_wanted);
                repeat (6) begin
                    hay_byte(alpha_byte());
                    end_haystack();
                end
            end
            if ($urandom_range(0, 3) == 0)
                define_table();
            if ($urandom_range(0, 5) == 0)
                set_count(pick_count());
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 24);
            stream_haystack(n);
            // sometimes the haystack carries on into the next round
            if ($urandom_range(0, 9) != 0)
                end_haystack();
        end

        // a short search afterwards shows the state was cleared
        in_burst = 1'b0;
        set_count(pick_count());
        stream_haystack(10);
        end_haystack();

        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("multi_pattern_first_match regression: pass");
        else
            $display("multi_pattern_first_match regression: fail");
        $finish;
    end

endmodule
